// ===== sv/irow_pkg.sv =====
// shared constants and the stage control type for the 8-point row idct
// no dependencies; imported by every module of the block
package irow_pkg;

  // pipeline depth and result width
  localparam int NUM_STAGES = 5;
  localparam int PIX_WIDTH  = 23;

  // butterfly constants, round(2048 * sqrt(2) * cos(k * pi / 16))
  localparam int W1 = 2841;
  localparam int W2 = 2676;
  localparam int W3 = 2408;
  localparam int W5 = 1609;
  localparam int W6 = 1108;
  localparam int W7 = 565;

  // 45-degree rotation (181/256), rounding bias and fixed-point shifts
  localparam int ROT        = 181;
  localparam int RBIAS      = 128;
  localparam int DC_SHIFT   = 11;
  localparam int FRAC_SHIFT = 8;
  localparam int DC8_SHIFT  = 3;

  // per-stage load enables and valid bits, driven by the stage controller
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
    logic [NUM_STAGES-1:0] vld;
  } irow_ctl_t;

endpackage

// ===== sv/idct_row_8point.sv =====
// top level of the 8-point integer row idct
// depends on irow_pkg, irow_ctrl, irow_butterfly, irow_rotate

// One row of eight signed coefficients goes in per beat and eight 23-bit
// spatial samples come out; the pipeline takes a new row every cycle
// while in_ready is high. Stages: constant products, odd/even terms,
// butterflies, rotation products, then final butterfly into the output
// register. A row whose seven ac coefficients are all zero yields eight
// times the dc value on every output. Back-pressure on the output ripples
// back stage by stage, so in_ready only drops once all five stages hold a
// row and the output is stalled; nothing is kept from one row to the next.
module idct_row_8point #(
  parameter int COEF_WIDTH = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COEF_WIDTH-1:0]          coef_0,
  input  logic signed [COEF_WIDTH-1:0]          coef_1,
  input  logic signed [COEF_WIDTH-1:0]          coef_2,
  input  logic signed [COEF_WIDTH-1:0]          coef_3,
  input  logic signed [COEF_WIDTH-1:0]          coef_4,
  input  logic signed [COEF_WIDTH-1:0]          coef_5,
  input  logic signed [COEF_WIDTH-1:0]          coef_6,
  input  logic signed [COEF_WIDTH-1:0]          coef_7,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [irow_pkg::PIX_WIDTH-1:0] pix_0,
  output logic signed [irow_pkg::PIX_WIDTH-1:0] pix_1,
  output logic signed [irow_pkg::PIX_WIDTH-1:0] pix_2,
  output logic signed [irow_pkg::PIX_WIDTH-1:0] pix_3,
  output logic signed [irow_pkg::PIX_WIDTH-1:0] pix_4,
  output logic signed [irow_pkg::PIX_WIDTH-1:0] pix_5,
  output logic signed [irow_pkg::PIX_WIDTH-1:0] pix_6,
  output logic signed [irow_pkg::PIX_WIDTH-1:0] pix_7
);
  import irow_pkg::*;

  // working width covers the rotation products before their shift
  localparam int WW = COEF_WIDTH + 24;

  irow_ctl_t            ctl;
  logic signed [WW-1:0] p0, p1, p2, p3, s46, d46, s57, d57;
  logic                 dc_only;
  logic signed [COEF_WIDTH-1:0] dc;
  logic signed [PIX_WIDTH-1:0]  pix [8];

  // stage valid bits and load enables
  irow_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  // products, odd/even terms and butterflies
  irow_butterfly #(
    .CW (COEF_WIDTH),
    .WW (WW)
  ) u_butterfly (
    .clk     (clk),
    .ctl     (ctl),
    .coef_0  (coef_0),
    .coef_1  (coef_1),
    .coef_2  (coef_2),
    .coef_3  (coef_3),
    .coef_4  (coef_4),
    .coef_5  (coef_5),
    .coef_6  (coef_6),
    .coef_7  (coef_7),
    .p0      (p0),
    .p1      (p1),
    .p2      (p2),
    .p3      (p3),
    .s46     (s46),
    .d46     (d46),
    .s57     (s57),
    .d57     (d57),
    .dc_only (dc_only),
    .dc      (dc)
  );

  // rotation and final butterfly
  irow_rotate #(
    .CW (COEF_WIDTH),
    .WW (WW)
  ) u_rotate (
    .clk     (clk),
    .ctl     (ctl),
    .p0      (p0),
    .p1      (p1),
    .p2      (p2),
    .p3      (p3),
    .s46     (s46),
    .d46     (d46),
    .s57     (s57),
    .d57     (d57),
    .dc_only (dc_only),
    .dc      (dc),
    .pix     (pix)
  );

  // output beat
  assign out_valid = ctl.vld[NUM_STAGES-1];
  assign pix_0     = pix[0];
  assign pix_1     = pix[1];
  assign pix_2     = pix[2];
  assign pix_3     = pix[3];
  assign pix_4     = pix[4];
  assign pix_5     = pix[5];
  assign pix_6     = pix[6];
  assign pix_7     = pix[7];

endmodule

// ===== sv/irow_ctrl.sv =====
// stage controller: valid bits and load enables for the row idct pipeline
// depends on irow_pkg
module irow_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               out_ready,
  output irow_pkg::irow_ctl_t ctl
);
  import irow_pkg::*;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] vld_next;
  logic [NUM_STAGES-1:0] en;

  // a stage may load when it is empty or its contents move on
  always_comb begin
    en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  // valid bits follow the data
  always_comb begin
    vld_next[0] = en[0] ? in_valid : vld[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      vld_next[i] = en[i] ? vld[i-1] : vld[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= vld_next;
    end
  end

  assign in_ready = en[0];
  assign ctl.en   = en;
  assign ctl.vld  = vld;

`ifndef NO_ASSERTIONS
  // a stalled stage keeps its beat
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (($past(vld & ~en) & ~vld) == '0))
    else $error("stalled stage lost its beat");

  // input back-pressure only when every stage is full and the output is stalled
  a_ready_low_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> ((&vld) && !out_ready))
    else $error("input stalled while pipeline has room");

  // an accepted beat lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted beat missing from first stage");
`endif

endmodule

// ===== sv/irow_butterfly.sv =====
// first three pipeline stages: constant products, odd/even terms, butterflies
// depends on irow_pkg; fed by irow_ctrl enables
module irow_butterfly #(
  parameter int CW = 16,
  parameter int WW = 40
) (
  input  logic                     clk,
  input  irow_pkg::irow_ctl_t      ctl,
  input  logic signed [CW-1:0]     coef_0,
  input  logic signed [CW-1:0]     coef_1,
  input  logic signed [CW-1:0]     coef_2,
  input  logic signed [CW-1:0]     coef_3,
  input  logic signed [CW-1:0]     coef_4,
  input  logic signed [CW-1:0]     coef_5,
  input  logic signed [CW-1:0]     coef_6,
  input  logic signed [CW-1:0]     coef_7,
  output logic signed [WW-1:0]     p0,
  output logic signed [WW-1:0]     p1,
  output logic signed [WW-1:0]     p2,
  output logic signed [WW-1:0]     p3,
  output logic signed [WW-1:0]     s46,
  output logic signed [WW-1:0]     d46,
  output logic signed [WW-1:0]     s57,
  output logic signed [WW-1:0]     d57,
  output logic                     dc_only,
  output logic signed [CW-1:0]     dc
);
  import irow_pkg::*;

  localparam logic signed [WW-1:0] K_W7      = WW'(W7);
  localparam logic signed [WW-1:0] K_W1_M_W7 = WW'(W1 - W7);
  localparam logic signed [WW-1:0] K_W1_P_W7 = WW'(W1 + W7);
  localparam logic signed [WW-1:0] K_W3      = WW'(W3);
  localparam logic signed [WW-1:0] K_W3_M_W5 = WW'(W3 - W5);
  localparam logic signed [WW-1:0] K_W3_P_W5 = WW'(W3 + W5);
  localparam logic signed [WW-1:0] K_W6      = WW'(W6);
  localparam logic signed [WW-1:0] K_W2_P_W6 = WW'(W2 + W6);
  localparam logic signed [WW-1:0] K_W2_M_W6 = WW'(W2 - W6);
  localparam logic signed [WW-1:0] K_RBIAS   = WW'(RBIAS);

  logic signed [WW-1:0] c [8];

  // stage 0 registers
  logic signed [WW-1:0] t1, m1, m7, t2, m5, m3, r, m6, m2, a0, a1;
  logic                 dc_only0;
  logic signed [CW-1:0] dc0;

  // stage 1 registers
  logic signed [WW-1:0] a4, a5, a6, a7, e2, e3, s01, d01;
  logic                 dc_only1;
  logic signed [CW-1:0] dc1;

  // sign-extend the coefficients to the working width
  assign c[0] = {{(WW-CW){coef_0[CW-1]}}, coef_0};
  assign c[1] = {{(WW-CW){coef_1[CW-1]}}, coef_1};
  assign c[2] = {{(WW-CW){coef_2[CW-1]}}, coef_2};
  assign c[3] = {{(WW-CW){coef_3[CW-1]}}, coef_3};
  assign c[4] = {{(WW-CW){coef_4[CW-1]}}, coef_4};
  assign c[5] = {{(WW-CW){coef_5[CW-1]}}, coef_5};
  assign c[6] = {{(WW-CW){coef_6[CW-1]}}, coef_6};
  assign c[7] = {{(WW-CW){coef_7[CW-1]}}, coef_7};

  // stage 0: constant products and the dc-only check
  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      t1       <= K_W7 * (c[1] + c[7]);
      m1       <= K_W1_M_W7 * c[1];
      m7       <= K_W1_P_W7 * c[7];
      t2       <= K_W3 * (c[5] + c[3]);
      m5       <= K_W3_M_W5 * c[5];
      m3       <= K_W3_P_W5 * c[3];
      r        <= K_W6 * (c[2] + c[6]);
      m6       <= K_W2_P_W6 * c[6];
      m2       <= K_W2_M_W6 * c[2];
      a0       <= (c[0] <<< DC_SHIFT) + K_RBIAS;
      a1       <= c[4] <<< DC_SHIFT;
      dc_only0 <= ((coef_1 | coef_2 | coef_3 | coef_4 | coef_5 | coef_6 | coef_7) == '0);
      dc0      <= coef_0;
    end
  end

  // stage 1: odd and even terms
  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      a4       <= t1 + m1;
      a5       <= t1 - m7;
      a6       <= t2 - m5;
      a7       <= t2 - m3;
      e2       <= r - m6;
      e3       <= r + m2;
      s01      <= a0 + a1;
      d01      <= a0 - a1;
      dc_only1 <= dc_only0;
      dc1      <= dc0;
    end
  end

  // stage 2: butterflies
  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      s46     <= a4 + a6;
      d46     <= a4 - a6;
      s57     <= a5 + a7;
      d57     <= a5 - a7;
      p0      <= s01 + e3;
      p3      <= s01 - e3;
      p1      <= d01 + e2;
      p2      <= d01 - e2;
      dc_only <= dc_only1;
      dc      <= dc1;
    end
  end

endmodule

// ===== sv/irow_rotate.sv =====
// last two pipeline stages: 181/256 rotation, final butterfly and output register
// depends on irow_pkg; fed by irow_butterfly and irow_ctrl
module irow_rotate #(
  parameter int CW = 16,
  parameter int WW = 40
) (
  input  logic                                  clk,
  input  irow_pkg::irow_ctl_t                   ctl,
  input  logic signed [WW-1:0]                  p0,
  input  logic signed [WW-1:0]                  p1,
  input  logic signed [WW-1:0]                  p2,
  input  logic signed [WW-1:0]                  p3,
  input  logic signed [WW-1:0]                  s46,
  input  logic signed [WW-1:0]                  d46,
  input  logic signed [WW-1:0]                  s57,
  input  logic signed [WW-1:0]                  d57,
  input  logic                                  dc_only,
  input  logic signed [CW-1:0]                  dc,
  output logic signed [irow_pkg::PIX_WIDTH-1:0] pix [8]
);
  import irow_pkg::*;

  localparam logic signed [WW-1:0] K_ROT   = WW'(ROT);
  localparam logic signed [WW-1:0] K_RBIAS = WW'(RBIAS);

  // stage 3 registers
  logic signed [WW-1:0] rq1, rq2, p0_r, p1_r, p2_r, p3_r, s46_r, s57_r;
  logic                 dc_only_r;
  logic signed [CW-1:0] dc_r;

  logic signed [WW-1:0] q1, q2, dc8;
  logic signed [WW-1:0] sum [8];
  logic signed [WW-1:0] res [8];

  // stage 3: rotation products with rounding bias
  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      rq1       <= K_ROT * (d46 + d57) + K_RBIAS;
      rq2       <= K_ROT * (d46 - d57) + K_RBIAS;
      p0_r      <= p0;
      p1_r      <= p1;
      p2_r      <= p2;
      p3_r      <= p3;
      s46_r     <= s46;
      s57_r     <= s57;
      dc_only_r <= dc_only;
      dc_r      <= dc;
    end
  end

  // final butterfly with floor shifts
  always_comb begin
    q1     = rq1 >>> FRAC_SHIFT;
    q2     = rq2 >>> FRAC_SHIFT;
    sum[0] = p0_r + s46_r;
    sum[1] = p1_r + q1;
    sum[2] = p2_r + q2;
    sum[3] = p3_r + s57_r;
    sum[4] = p3_r - s57_r;
    sum[5] = p2_r - q2;
    sum[6] = p1_r - q1;
    sum[7] = p0_r - s46_r;
    dc8    = {{(WW-CW){dc_r[CW-1]}}, dc_r} <<< DC8_SHIFT;
    for (int k = 0; k < 8; k++) begin
      res[k] = dc_only_r ? dc8 : (sum[k] >>> FRAC_SHIFT);
    end
  end

  // stage 4: output register, wrapped to the result width
  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      for (int k = 0; k < 8; k++) begin
        pix[k] <= res[k][PIX_WIDTH-1:0];
      end
    end
  end

endmodule
